@@ rtl/hcbt_pkg.sv @@
// Shared types and constants for the Hill cipher block transform.
// No dependencies; imported by hill_cipher_block_transform.
`default_nettype none

package hcbt_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_RED,
    ST_EMIT
  } hcbt_state_t;

  localparam int KEY_DIM   = 3;               // key is always stored as 3x3
  localparam int KEY_W     = 5;               // bits per key entry
  localparam int KEY_ENT   = KEY_DIM * KEY_DIM;
  localparam int KEYMAT_W  = KEY_W * KEY_ENT; // 45
  localparam int LET_W     = 5;               // letter value 0..25
  localparam int ACC_W     = 12;              // row sum up to 3*31*25
  localparam int MUL_W     = 2 * ACC_W;
  localparam int QUO_W     = 7;               // sum / 26 up to 89
  localparam int RECIP_SH  = 16;

  localparam logic [ACC_W-1:0] RECIP26  = 12'd2521; // ceil(2^16 / 26)
  localparam logic [LET_W-1:0] PAD_LET  = 5'd23;    // 'x'
  localparam logic [6:0]       BASE_LC  = 7'd97;    // 'a'
  localparam logic [7:0]       UC_FIRST = 8'd65;
  localparam logic [7:0]       UC_LAST  = 8'd90;
  localparam logic [7:0]       LC_FIRST = 8'd97;
  localparam logic [7:0]       LC_LAST  = 8'd122;

  // register map, decoded on paddr[3]
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_KEY_MATRIX = 1'b1;

  localparam logic [1:0]          BLOCK_SIZE_RST = 2'd2;

endpackage

`default_nettype wire

@@ rtl/hill_cipher_block_transform.sv @@
// Hill cipher block transform: letter intake, MAC sequencer, APB registers.
// Depends on hcbt_pkg.
`default_nettype none

// Text bytes come in one beat at a time. Non-letters are dropped, capitals
// are folded, and each letter is kept as 0..25 until a block of n letters
// (n = block_size, clamped to 1..MAX_DIM) is full. A full block, or a
// partial block on end_of_text (padded with 'x'), is sent out as n beats:
// row j is sum_k key[j][k]*letter[k] mod 26, as lowercase ASCII, with
// last_of_run on the last row and message_done on the last row of the
// message. A byte that completes no block is accepted without a stall.
// A byte that flushes a block starts the sequencer: one shared 12x12
// multiplier does every key*letter product of a row in turn, then
// reuses itself for the reciprocal step of the mod 26, and a last
// state per row loads the output register once the output side can
// take it. in_stall is high for the whole flush.
// Registers: block_size at byte 0x0 (2 bits, reset 2), key_matrix at 0x8
// (45 bits, reset 0, entry j*3+k at bits 5*(j*3+k)). Write them only while
// the block is idle.
module hill_cipher_block_transform
  import hcbt_pkg::*;
#(
  parameter int MAX_DIM = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  raw_char,
  input  wire logic        end_of_text,
  // output beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       cipher_char,
  output logic             last_of_run,
  output logic             message_done,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] DIM_MAX = 2'(MAX_DIM);

  // ---------------- config registers ----------------
  logic [1:0]          block_size;
  logic [KEYMAT_W-1:0] key_matrix;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RST;
      key_matrix <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_KEY_MATRIX) begin
        key_matrix <= pwdata[KEYMAT_W-1:0];
      end else begin
        block_size <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_KEY_MATRIX) begin
      prdata = {{(64-KEYMAT_W){1'b0}}, key_matrix};
    end else begin
      prdata = {62'd0, block_size};
    end
  end

  // effective dimension, clamped to 1..MAX_DIM
  logic [1:0] dim;
  always_comb begin
    if (block_size == 2'd0) begin
      dim = 2'd1;
    end else if (block_size > DIM_MAX) begin
      dim = DIM_MAX;
    end else begin
      dim = block_size;
    end
  end

  // ---------------- state ----------------
  hcbt_state_t         state, state_next;
  logic [LET_W-1:0]    letter_buffer [MAX_DIM];
  logic [LET_W-1:0]    letter_buffer_next [MAX_DIM];
  logic [1:0]          fill_count, fill_count_next;
  logic [1:0]          row, row_next;      // j
  logic [1:0]          col, col_next;      // k
  logic [ACC_W-1:0]    acc, acc_next;
  logic [QUO_W-1:0]    quo, quo_next;
  logic [1:0]          run_dim, run_dim_next;
  logic                run_eot, run_eot_next;
  logic                out_load;

  // ---------------- intake decode ----------------
  logic             is_upper, is_lower, is_letter;
  logic [LET_W-1:0] let_val;
  logic             wr_letter;
  logic [1:0]       fill_after;
  logic             flush;
  logic             pad_on;

  always_comb begin
    is_upper  = (raw_char >= UC_FIRST) && (raw_char <= UC_LAST);
    is_lower  = (raw_char >= LC_FIRST) && (raw_char <= LC_LAST);
    is_letter = is_upper || is_lower;
    if (is_lower) begin
      let_val = LET_W'(raw_char - LC_FIRST);
    end else begin
      let_val = LET_W'(raw_char - UC_FIRST);
    end
    wr_letter  = is_letter && (fill_count < dim);
    fill_after = fill_count + {1'b0, wr_letter};
    pad_on     = end_of_text && (fill_after != 2'd0);
    // stale count after n was lowered: flush only on a letter or end of text
    if (is_letter) begin
      flush = (fill_after >= dim) || pad_on;
    end else begin
      flush = ((fill_count >= dim) && end_of_text) || pad_on;
    end
  end

  // ---------------- shared multiplier ----------------
  logic [KEY_W-1:0] key_sel;
  logic [LET_W-1:0] let_sel;
  logic [3:0]       key_pos;
  logic [ACC_W-1:0] mul_a, mul_b;
  logic [MUL_W-1:0] mul_p;

  always_comb begin
    key_pos = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    key_sel = '0;
    for (int e = 0; e < KEY_ENT; e++) begin
      if (key_pos == 4'(e)) key_sel = key_matrix[KEY_W*e +: KEY_W];
    end
    let_sel = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (col == 2'(i)) let_sel = letter_buffer[i];
    end
  end

  // MAC: key * letter; reduce: acc * ceil(2^16/26)
  always_comb begin
    if (state == ST_RED) begin
      mul_a = acc;
      mul_b = RECIP26;
    end else begin
      mul_a = {{(ACC_W-KEY_W){1'b0}}, key_sel};
      mul_b = {{(ACC_W-LET_W){1'b0}}, let_sel};
    end
    mul_p = mul_a * mul_b;
  end

  // remainder: acc - 26*q
  logic [ACC_W-1:0] q26;
  logic [ACC_W-1:0] rem_full;
  assign q26      = {1'b0, quo, 4'b0} + {2'b0, quo, 3'b0} + {4'b0, quo, 1'b0};
  assign rem_full = acc - q26;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    letter_buffer <= letter_buffer_next;
    row           <= row_next;
    col           <= col_next;
    acc           <= acc_next;
    quo           <= quo_next;
    run_dim       <= run_dim_next;
    run_eot       <= run_eot_next;
  end

  always_comb begin
    state_next         = state;
    fill_count_next    = fill_count;
    letter_buffer_next = letter_buffer;
    row_next           = row;
    col_next           = col;
    acc_next           = acc;
    quo_next           = quo;
    run_dim_next       = run_dim;
    run_eot_next       = run_eot;
    out_load           = 1'b0;
    in_stall           = 1'b1;

    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          for (int i = 0; i < MAX_DIM; i++) begin
            if (wr_letter && (fill_count == 2'(i))) begin
              letter_buffer_next[i] = let_val;
            end else if (pad_on && (2'(i) >= fill_after) && (2'(i) < dim)) begin
              letter_buffer_next[i] = PAD_LET;
            end
          end
          if (flush) begin
            fill_count_next = '0;
            run_dim_next    = dim;
            run_eot_next    = end_of_text;
            row_next        = '0;
            col_next        = '0;
            acc_next        = '0;
            state_next      = ST_MAC;
          end else begin
            fill_count_next = fill_after;
          end
        end
      end

      ST_MAC: begin
        acc_next = acc + mul_p[ACC_W-1:0];
        if (col == run_dim - 2'd1) begin
          state_next = ST_RED;
        end else begin
          col_next = col + 2'd1;
        end
      end

      ST_RED: begin
        quo_next   = mul_p[RECIP_SH +: QUO_W];
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          if (row == run_dim - 2'd1) begin
            state_next = ST_IDLE;
          end else begin
            row_next   = row + 2'd1;
            col_next   = '0;
            acc_next   = '0;
            state_next = ST_MAC;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cipher_char  <= BASE_LC + {2'b00, rem_full[LET_W-1:0]};
      last_of_run  <= (row == run_dim - 2'd1);
      message_done <= (row == run_dim - 2'd1) && run_eot;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_hill_cipher_block_transform.sv @@
// Self-checking testbench for hill_cipher_block_transform: text beats in,
// cipher letter beats out, predicted and checked by an in-bench scoreboard.
// Depends on hcbt_pkg and the RTL top; needs no files or arguments.
`default_nettype none

module tb_hill_cipher_block_transform
  import hcbt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CIPHER_MOD   = 26;
  localparam int  DRAIN_CYCLES = 24;
  localparam int  HOLD_CYCLES  = 150;    // receiver hold-off for backpressure
  localparam int  PHASE_BEATS  = 56;
  localparam int  NUM_PHASES   = 8;
  localparam real TIMEOUT_NS   = 4.0e6;  // far above a slow pass

  // one expected output beat
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       done;
  } cipher_beat_t;

  // Scoreboard: keeps its own copy of the registers and the partial block,
  // turns each accepted text beat into the cipher letters it should produce.
  class cipher_scoreboard;
    logic [1:0]          size_reg;
    logic [KEYMAT_W-1:0] key_reg;
    logic [LET_W-1:0]    letters [KEY_DIM];
    int                  fill;
    cipher_beat_t        pending_letters [$];
    int                  errors;
    int                  checked;

    function new();
      size_reg = BLOCK_SIZE_RST;
      key_reg  = '0;
      fill     = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(logic sel, logic [63:0] val);
      if (sel == REG_BLOCK_SIZE) begin
        size_reg = val[1:0];
      end else begin
        key_reg = val[KEYMAT_W-1:0];
      end
    endfunction

    // block size clamps to 1..KEY_DIM
    function int dim();
      if (size_reg == 2'd0) return 1;
      if (int'(size_reg) > KEY_DIM) return KEY_DIM;
      return int'(size_reg);
    endfunction

    function void encipher_byte(logic [7:0] c, logic eot);
      int           n;
      int           cnt;
      int           sum;
      bit           flush;
      bit           is_letter;
      cipher_beat_t beat;
      n         = dim();
      cnt       = fill;
      flush     = 1'b0;
      is_letter = (c >= UC_FIRST && c <= UC_LAST) || (c >= LC_FIRST && c <= LC_LAST);
      if (is_letter) begin
        // a letter that finds the block already full is dropped
        if (cnt < n) begin
          letters[cnt] = (c >= LC_FIRST) ? LET_W'(c - LC_FIRST) : LET_W'(c - UC_FIRST);
          cnt++;
        end
        if (cnt >= n) flush = 1'b1;
      end else if (cnt >= n) begin
        flush = eot;
      end
      if (eot && cnt > 0) begin
        for (int k = cnt; k < n; k++) letters[k] = PAD_LET;
        flush = 1'b1;
      end
      if (!flush) begin
        fill = cnt;
        return;
      end
      for (int j = 0; j < n; j++) begin
        sum = 0;
        for (int k = 0; k < n; k++) begin
          sum += int'(key_reg[KEY_W*(j*KEY_DIM+k) +: KEY_W]) * int'(letters[k]);
        end
        beat.ch   = BASE_LC + 7'(sum % CIPHER_MOD);
        beat.last = (j == n - 1);
        beat.done = eot && (j == n - 1);
        pending_letters.insert(pending_letters.size(), beat);
      end
      fill = 0;
    endfunction

    function void check_beat(logic [6:0] ch, logic last, logic done);
      cipher_beat_t want;
      if (pending_letters.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual ch %0d last %0d done %0d",
                 $time, ch, last, done);
        return;
      end
      want = pending_letters.pop_front();
      checked++;
      if (want.ch !== ch) begin
        errors++;
        $display("%0t: cipher_char expected %0d actual %0d", $time, want.ch, ch);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, last);
      end
      if (want.done !== done) begin
        errors++;
        $display("%0t: message_done expected %0d actual %0d", $time, want.done, done);
      end
    endfunction

    function int pending();
      return pending_letters.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  raw_char;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  cipher_char;
  logic        last_of_run;
  logic        message_done;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  cipher_scoreboard sb;

  // knobs shared between the stimulus and receiver processes
  int idle_pct  = 0;   // sender gap chance per beat, percent
  int stall_pct = 0;   // receiver stall chance per cycle, percent
  bit hold_off  = 0;   // one-shot request for a long receiver stall
  int beats_sent = 0;
  int settings_used = 0;

  hill_cipher_block_transform #(
    .MAX_DIM(KEY_DIM)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_char     (raw_char),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_char  (cipher_char),
    .last_of_run  (last_of_run),
    .message_done (message_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block wedges.
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // block backs up and pushes stall onto the input side.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Output monitor: values sampled at the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_beat(cipher_char, last_of_run, message_done);
    end
  end

  // APB write: setup cycle, then access until pready. The bus is left
  // selected so a following write can start in the same step.
  task automatic reg_write(input logic sel, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(sel, val);
  endtask

  // Present one text beat and hold it until accepted. valid stays high
  // into the next call unless a gap is taken here.
  task automatic send_beat(input logic [7:0] c, input logic eot);
    in_valid    <= 1'b1;
    raw_char    <= c;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    sb.encipher_byte(c, eot);
    beats_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Text string, end_of_text optionally on its last byte.
  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  // Wait out every expected letter, then let a non-flushing beat settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly letters of both cases, some arbitrary bytes, occasional
  // end of text so messages of every length get flushed.
  task automatic random_beat();
    logic [7:0] c;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 45)      c = LC_FIRST + 8'($urandom_range(25));
    else if (pick < 70) c = UC_FIRST + 8'($urandom_range(25));
    else if (pick < 92) c = 8'($urandom_range(255));
    else                c = " ";
    send_beat(c, $urandom_range(99) < 7);
  endtask

  task automatic configure(input logic [1:0] bs, input logic [63:0] keyv);
    logic [63:0] word;
    word      = {$urandom, $urandom};   // junk above the field is ignored
    word[1:0] = bs;
    reg_write(REG_BLOCK_SIZE, word);
    reg_write(REG_KEY_MATRIX, keyv);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [1:0]  bs;
    logic [63:0] keyv;
    sb          = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    raw_char    <= 8'h00;
    end_of_text <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: n = 2, zero key, every letter maps to 'a'
    send_text("Hi", 1'b0);
    drain();

    // full-scale key, n = 3: letter extremes, non-letter edges around
    // both letter ranges, high bytes, pad on a partial block
    configure(2'd3, '1);
    send_text("AZz", 1'b0);
    send_text("a@[`{", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b1);
    send_beat(".", 1'b1);          // end of text on an empty block: silent
    send_text("QrS", 1'b1);        // end of text on a completing letter
    send_beat("m", 1'b1);          // end of text on a lone letter: two pads
    send_text("bc", 1'b0);         // leave two letters stored
    drain();

    // size lowered under a partly filled block: next letter flushes the
    // first stored letter and is itself dropped
    configure(2'd1, {$urandom, $urandom});
    send_beat("d", 1'b0);
    drain();
    configure(2'd3, {$urandom, $urandom});
    send_text("ef", 1'b0);
    drain();
    // size zero clamps to one; stored letters beyond it wait for a flush
    configure(2'd0, {$urandom, $urandom});
    send_beat("!", 1'b0);
    send_beat("?", 1'b1);
    send_beat("g", 1'b0);
    drain();

    // random phases; partial blocks carry across setting changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      bs   = 2'($urandom_range(3));
      keyv = {$urandom, $urandom};
      idle_pct  = 23;
      stall_pct = 23;
      case (p)
        0: begin
          bs        = 2'd3;
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          bs   = 2'd1;
          keyv = '0;
        end
        2: bs = 2'd0;
        3: begin
          bs   = 2'd3;
          keyv = '1;
        end
        default: ;
      endcase
      configure(bs, keyv);
      if (p == 4) begin
        // long receiver hold while the sender keeps pushing
        idle_pct = 0;
        hold_off = 1'b1;
      end
      repeat (PHASE_BEATS) random_beat();
      drain();
    end

    sb.errors += sb.pending();
    $display("Sent %0d text beats over %0d register settings, checked %0d cipher letters.",
             beats_sent, settings_used, sb.checked);
    $display("Included block sizes 0..3, zero and full keys, padding and one long hold-off.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/hcbt_pkg.sv
rtl/hill_cipher_block_transform.sv
tb/sv/tb_hill_cipher_block_transform.sv
